// ===== src/asdcrc_pkg.sv =====
// Package for the archive deframer: item codes, result record and CRC-32 byte step.
// No dependencies; every other file depends on it.
`timescale 1ns / 1ps

package asdcrc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;
  localparam int unsigned KindW  = 3;
  localparam int unsigned StatW  = 3;

  localparam logic [WordW-1:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] CrcPoly = 32'hEDB8_8320;

  localparam logic [KindW-1:0] KIND_COUNT   = 3'd0;
  localparam logic [KindW-1:0] KIND_PLEN    = 3'd1;
  localparam logic [KindW-1:0] KIND_PATH    = 3'd2;
  localparam logic [KindW-1:0] KIND_CLEN    = 3'd3;
  localparam logic [KindW-1:0] KIND_DIR     = 3'd4;
  localparam logic [KindW-1:0] KIND_CRC     = 3'd5;
  localparam logic [KindW-1:0] KIND_CONTENT = 3'd6;
  localparam logic [KindW-1:0] KIND_IGNORED = 3'd7;

  localparam logic [StatW-1:0] ST_BUSY     = 3'd0;
  localparam logic [StatW-1:0] ST_ENTRY_OK = 3'd1;
  localparam logic [StatW-1:0] ST_ARCH_OK  = 3'd2;
  localparam logic [StatW-1:0] ST_CRC_BAD  = 3'd3;
  localparam logic [StatW-1:0] ST_TRUNC    = 3'd4;
  localparam logic [StatW-1:0] ST_IGNORED  = 3'd5;

  typedef struct packed {
    logic [KindW-1:0] byte_kind;
    logic [ByteW-1:0] byte_value;
    logic [WordW-1:0] entry_number;
    logic [StatW-1:0] status;
  } result_t;

  // reflected CRC-32, one byte, bit at a time
  function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [WordW-1:0] c;
    c = crc ^ {{(WordW-ByteW){1'b0}}, b};
    for (int i = 0; i < ByteW; i++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/asdcrc_in_if.sv =====
// Input channel: one archive byte with its final-byte flag, valid/ready handshake.
// Depends on asdcrc_pkg.
`timescale 1ns / 1ps

interface asdcrc_in_if;
  logic                       valid;
  logic                       ready;
  logic [asdcrc_pkg::ByteW-1:0] data_byte;
  logic                       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// ===== src/asdcrc_out_if.sv =====
// Output channel: tagged byte with entry number and status, valid/ready handshake.
// Depends on asdcrc_pkg.
`timescale 1ns / 1ps

interface asdcrc_out_if;
  logic                         valid;
  logic                         ready;
  logic [asdcrc_pkg::KindW-1:0] byte_kind;
  logic [asdcrc_pkg::ByteW-1:0] byte_value;
  logic [asdcrc_pkg::WordW-1:0] entry_number;
  logic [asdcrc_pkg::StatW-1:0] status;

  modport source (output valid, output byte_kind, output byte_value,
                  output entry_number, output status, input ready);
  modport sink   (input valid, input byte_kind, input byte_value,
                  input entry_number, input status, output ready);
endinterface

// ===== src/asdcrc_parse.sv =====
// Field parser state and per-byte step: tags each byte, checks content CRC-32.
// Depends on asdcrc_pkg.
`timescale 1ns / 1ps

module asdcrc_parse (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         take,
  input  logic [asdcrc_pkg::ByteW-1:0] data_byte,
  input  logic                         final_byte,
  output asdcrc_pkg::result_t          result
);
  import asdcrc_pkg::*;

  typedef enum logic [2:0] {
    PH_COUNT, PH_PLEN, PH_PATH, PH_CLEN, PH_DIR, PH_CRC, PH_CONTENT, PH_IGNORE
  } phase_t;

  phase_t           phase, phase_next;
  logic [1:0]       pos, pos_next;
  logic [WordW-1:0] field_asm, field_asm_next;
  logic [WordW-1:0] entries_left, entries_left_next;
  logic [WordW-1:0] bytes_left, bytes_left_next;
  logic             dir_mark, dir_mark_next;
  logic [WordW-1:0] exp_crc, exp_crc_next;
  logic [WordW-1:0] run_crc, run_crc_next;
  logic [WordW-1:0] cur_entry, cur_entry_next;

  logic [WordW-1:0] gathered;
  logic [WordW-1:0] crc_step;
  logic [WordW-1:0] left_dec;
  logic             done2, done4;

  always_comb begin
    gathered = field_asm;
    gathered[{pos, 3'b000} +: ByteW] = data_byte;
    done2    = (pos == 2'd1);
    done4    = (pos == 2'd3);
    crc_step = crc_byte(run_crc, data_byte);
    left_dec = entries_left - 1'b1;
  end

  always_comb begin
    phase_next        = phase;
    pos_next          = pos;
    field_asm_next    = field_asm;
    entries_left_next = entries_left;
    bytes_left_next   = bytes_left;
    dir_mark_next     = dir_mark;
    exp_crc_next      = exp_crc;
    run_crc_next      = run_crc;
    cur_entry_next    = cur_entry;

    result.byte_value   = data_byte;
    result.entry_number = cur_entry;
    result.status       = ST_BUSY;
    result.byte_kind    = KIND_IGNORED;

    case (phase)
      PH_COUNT: begin
        result.byte_kind    = KIND_COUNT;
        result.entry_number = '0;
        if (done4) begin
          pos_next          = '0;
          field_asm_next    = '0;
          entries_left_next = gathered;
          if (gathered == '0) begin
            phase_next    = PH_IGNORE;
            result.status = ST_ARCH_OK;
          end else begin
            cur_entry_next = '0;
            phase_next     = PH_PLEN;
          end
        end else begin
          pos_next       = pos + 2'd1;
          field_asm_next = gathered;
        end
      end
      PH_PLEN: begin
        result.byte_kind = KIND_PLEN;
        if (done2 || done4) begin
          pos_next        = '0;
          field_asm_next  = '0;
          bytes_left_next = gathered;
          phase_next      = (gathered != '0) ? PH_PATH : PH_CLEN;
        end else begin
          pos_next       = pos + 2'd1;
          field_asm_next = gathered;
        end
      end
      PH_PATH: begin
        result.byte_kind = KIND_PATH;
        if (bytes_left <= 32'd1) begin
          bytes_left_next = '0;
          phase_next      = PH_CLEN;
        end else begin
          bytes_left_next = bytes_left - 1'b1;
        end
      end
      PH_CLEN: begin
        result.byte_kind = KIND_CLEN;
        if (done4) begin
          pos_next        = '0;
          field_asm_next  = '0;
          bytes_left_next = gathered;
          phase_next      = PH_DIR;
        end else begin
          pos_next       = pos + 2'd1;
          field_asm_next = gathered;
        end
      end
      PH_DIR: begin
        result.byte_kind = KIND_DIR;
        dir_mark_next    = (data_byte == 8'd1);
        phase_next       = PH_CRC;
      end
      PH_CRC: begin
        result.byte_kind = KIND_CRC;
        if (done4) begin
          pos_next       = '0;
          field_asm_next = '0;
          exp_crc_next   = gathered;
          if (!dir_mark && bytes_left != '0) begin
            run_crc_next = CrcInit;
            phase_next   = PH_CONTENT;
          end else begin
            entries_left_next = left_dec;
            cur_entry_next    = cur_entry + 1'b1;
            phase_next        = (left_dec == '0) ? PH_IGNORE : PH_PLEN;
            result.status     = (left_dec == '0) ? ST_ARCH_OK : ST_ENTRY_OK;
          end
        end else begin
          pos_next       = pos + 2'd1;
          field_asm_next = gathered;
        end
      end
      PH_CONTENT: begin
        result.byte_kind = KIND_CONTENT;
        run_crc_next     = crc_step;
        if (bytes_left <= 32'd1) begin
          bytes_left_next = '0;
          if ((crc_step ^ CrcInit) != exp_crc) begin
            phase_next    = PH_IGNORE;
            result.status = ST_CRC_BAD;
          end else begin
            entries_left_next = left_dec;
            cur_entry_next    = cur_entry + 1'b1;
            phase_next        = (left_dec == '0) ? PH_IGNORE : PH_PLEN;
            result.status     = (left_dec == '0) ? ST_ARCH_OK : ST_ENTRY_OK;
          end
        end else begin
          bytes_left_next = bytes_left - 1'b1;
        end
      end
      default: begin
        result.byte_kind    = KIND_IGNORED;
        result.entry_number = '0;
        result.status       = ST_IGNORED;
      end
    endcase

    if (final_byte) begin
      if (!(result.status inside {ST_ARCH_OK, ST_CRC_BAD, ST_IGNORED})) begin
        result.status = ST_TRUNC;
      end
      phase_next        = PH_COUNT;
      pos_next          = '0;
      field_asm_next    = '0;
      entries_left_next = '0;
      bytes_left_next   = '0;
      dir_mark_next     = 1'b0;
      exp_crc_next      = '0;
      run_crc_next      = CrcInit;
      cur_entry_next    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_COUNT;
      pos          <= '0;
      field_asm    <= '0;
      entries_left <= '0;
      bytes_left   <= '0;
      dir_mark     <= 1'b0;
      exp_crc      <= '0;
      run_crc      <= CrcInit;
      cur_entry    <= '0;
    end else if (take) begin
      phase        <= phase_next;
      pos          <= pos_next;
      field_asm    <= field_asm_next;
      entries_left <= entries_left_next;
      bytes_left   <= bytes_left_next;
      dir_mark     <= dir_mark_next;
      exp_crc      <= exp_crc_next;
      run_crc      <= run_crc_next;
      cur_entry    <= cur_entry_next;
    end
  end

endmodule

// ===== src/archive_stream_deframer_crc32_top.sv =====
// Channel   | Dir | Payload
// rx        | in  | data_byte[7:0], final_byte
// tx        | out | byte_kind[2:0], byte_value[7:0], entry_number[31:0], status[2:0]
//
// One item in, one item out; a new byte is taken every cycle while the skid register is empty.
// The parser state and the CRC-32 byte step sit in front of the output register; a skid
// register holds one item taken while the output is stalled, and rx.ready stays low until
// it drains. Reset (rst, synchronous) returns the parser to the count field.
// Top level of the archive deframer; depends on asdcrc_pkg, the channel interfaces
// and asdcrc_parse.
`timescale 1ns / 1ps

module archive_stream_deframer_crc32_top (
  input  logic         clk,
  input  logic         rst,
  asdcrc_in_if.sink    rx,
  asdcrc_out_if.source tx
);
  import asdcrc_pkg::*;

  logic    take;
  result_t step_res;
  result_t out_reg;
  result_t skid_reg;
  logic    out_valid;
  logic    skid_valid;

  assign rx.ready = !skid_valid;
  assign take     = rx.valid && rx.ready;

  asdcrc_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .data_byte  (rx.data_byte),
    .final_byte (rx.final_byte),
    .result     (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (tx.ready || !out_valid) begin
      if (skid_valid) begin
        out_reg    <= skid_reg;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_reg   <= step_res;
        out_valid <= take;
      end
    end else if (take) begin
      skid_reg   <= step_res;
      skid_valid <= 1'b1;
    end
  end

  assign tx.valid        = out_valid;
  assign tx.byte_kind    = out_reg.byte_kind;
  assign tx.byte_value   = out_reg.byte_value;
  assign tx.entry_number = out_reg.entry_number;
  assign tx.status       = out_reg.status;

endmodule

// ===== src/asdcrc_checker.sv =====
// Port-level checks for the archive deframer, bound to the top level.
// Depends on asdcrc_pkg and archive_stream_deframer_crc32_top.
`timescale 1ns / 1ps

module asdcrc_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [asdcrc_pkg::KindW-1:0] byte_kind,
  input logic [asdcrc_pkg::WordW-1:0] entry_number,
  input logic [asdcrc_pkg::StatW-1:0] status
);
  import asdcrc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(byte_kind))
    else $error("output item changed while stalled");

  a_ignored_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && (byte_kind == KIND_IGNORED || status == ST_IGNORED) |->
      byte_kind == KIND_IGNORED && status == ST_IGNORED && entry_number == '0)
    else $error("ignored item malformed");

  a_count_entry: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_kind == KIND_COUNT |-> entry_number == '0)
    else $error("count byte with nonzero entry");

  a_in_to_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid |=> out_valid)
    else $error("accepted item not presented");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("output not empty after reset");

endmodule

bind archive_stream_deframer_crc32_top asdcrc_checker u_asdcrc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (rx.valid),
  .in_ready     (rx.ready),
  .out_valid    (tx.valid),
  .out_ready    (tx.ready),
  .byte_kind    (tx.byte_kind),
  .entry_number (tx.entry_number),
  .status       (tx.status)
);
